[hdl/multilevel_priority_round_robin_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion templates shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_ROUND_ROBIN_QUEUE_TOP_MACROS_SVH
`define MULTILEVEL_PRIORITY_ROUND_ROBIN_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mprq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel priority queue package
// Constants and event codes for the round-robin run queue scheduler.
// ----------------------------------------------------------------------------
package mprq_pkg;

    localparam int NUM_TASKS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 10;

    localparam int AGING_W = 4;
    localparam logic [AGING_W-1:0] AGING_MAX   = 4'd15;
    localparam logic [AGING_W-1:0] AGING_RESET = 4'd3;

    localparam int FUNC_W = 2;
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FUNC_ENQ  = 2'd0;
    localparam t_func FUNC_DEQ  = 2'd1;
    localparam t_func FUNC_TICK = 2'd2;

endpackage

`default_nettype wire

[hdl/multilevel_priority_round_robin_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel priority round-robin run queue
// Linked-list run queues per priority level; links, levels and slice
// counters live in RAMs, level heads, tails and counts in registers.
//
//  channel   | ports                                       | handshake
//  ----------+---------------------------------------------+----------------
//  event in  | i_func, i_task_id, i_priority_req           | start / busy
//  result    | o_next_valid, o_next_task, o_resched,       | o_result_valid
//            | o_rejected                                  |
//  config    | i_cfg_wdata (aging limit)                   | i_cfg_we
//
// The RAMs are read at the transfer edge. A rotating tick then goes through
// the unlink, link and result states, searching heads in the last, and the
// strobe is registered after it. An enqueue takes link and result, a dequeue
// or plain tick unlink and result, a rejected event result only. Busy is
// high until the result strobe; the receiver cannot stall the result. Reset
// is synchronous and clears counts, queued flags and aged flags, so slice
// counters read as zero and no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multilevel_priority_round_robin_queue_top_macros.svh"

module multilevel_priority_round_robin_queue_top #(
    parameter int NUM_TASKS  = mprq_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = mprq_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [mprq_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [$clog2(NUM_TASKS)-1:0]  i_task_id,
    input  wire logic [$clog2(NUM_LEVELS)-1:0] i_priority_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [mprq_pkg::AGING_W-1:0]  i_cfg_wdata,
    output logic                               o_result_valid,
    output logic                               o_next_valid,
    output logic      [$clog2(NUM_TASKS)-1:0]  o_next_task,
    output logic                               o_resched,
    output logic                               o_rejected
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int AW = mprq_pkg::AGING_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UNL  = 2'd1;
    localparam logic [1:0] S_LNK  = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_aging_limit;

    mprq_pkg::t_func r_func;
    logic [TW-1:0]   r_tid;
    logic [LW-1:0]   r_lv, n_lv;
    logic            r_rej, n_rej;
    logic            r_rs, n_rs;
    logic            r_aged_hit;

    logic [TW-1:0] r_head  [NUM_LEVELS];
    logic [TW-1:0] r_tail  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];
    logic [NUM_TASKS-1:0] r_queued;
    logic [NUM_TASKS-1:0] r_aged;

    logic r_out_valid, r_out_nv, r_out_rs, r_out_rej;
    logic [TW-1:0] r_out_task;

    // RAM ports
    logic          accept;
    logic          next_we, prev_we, lvl_we, age_we;
    logic [TW-1:0] next_waddr, prev_waddr;
    logic [TW-1:0] next_wdata, prev_wdata;
    logic [TW-1:0] next_rd, prev_rd;
    logic [LW-1:0] lvl_rd;
    logic [AW-1:0] age_rd, age_wdata;

    logic [AW-1:0] age_cur, age_new;
    logic          rotate;
    logic          found;
    logic [LW-1:0] first_lv;
    logic          id_bad, lv_bad, enq_ok, deq_ok, tick_ok;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    mprq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_re(accept), .i_raddr(i_task_id), .o_rdata(next_rd)
    );
    mprq_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_re(accept), .i_raddr(i_task_id), .o_rdata(prev_rd)
    );
    mprq_ram #(.WIDTH(LW), .DEPTH(NUM_TASKS)) u_level_ram (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(r_tid), .i_wdata(r_lv),
        .i_re(accept), .i_raddr(i_task_id), .o_rdata(lvl_rd)
    );
    mprq_ram #(.WIDTH(AW), .DEPTH(NUM_TASKS)) u_aging_ram (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(r_tid), .i_wdata(age_wdata),
        .i_re(accept), .i_raddr(i_task_id), .o_rdata(age_rd)
    );

    // Acceptance checks use only the flag vectors, so rejection is known at once.
    always_comb begin
        id_bad  = ({1'b0, i_task_id} >= (TW+1)'(NUM_TASKS));
        lv_bad  = ({1'b0, i_priority_req} >= (LW+1)'(NUM_LEVELS));
        enq_ok  = (i_func == mprq_pkg::FUNC_ENQ) && !r_queued[i_task_id] && !lv_bad;
        deq_ok  = (i_func == mprq_pkg::FUNC_DEQ) && r_queued[i_task_id];
        tick_ok = (i_func == mprq_pkg::FUNC_TICK) && r_queued[i_task_id];
    end

    // Slice counter of the ticked task; a never-written entry reads as zero.
    always_comb begin
        age_cur = r_aged_hit ? age_rd : '0;
        age_new = (age_cur == mprq_pkg::AGING_MAX) ? age_cur : age_cur + AW'(1);
        rotate  = (age_new > r_aging_limit);
    end

    // Sequencer and RAM write selection.
    always_comb begin
        n_state    = r_state;
        n_lv       = r_lv;
        n_rej      = r_rej;
        n_rs       = r_rs;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        lvl_we     = 1'b0;
        age_we     = 1'b0;
        next_waddr = next_rd;
        next_wdata = r_tid;
        prev_waddr = r_tid;
        prev_wdata = prev_rd;
        age_wdata  = age_new;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_lv  = i_priority_req;
                    n_rs  = 1'b0;
                    n_rej = id_bad || !(enq_ok || deq_ok || tick_ok);
                    priority if (n_rej) begin
                        n_state = S_RES;
                    end else if (i_func == mprq_pkg::FUNC_ENQ) begin
                        n_state = S_LNK;
                    end else begin
                        n_state = S_UNL;
                    end
                end
            end
            S_UNL: begin
                n_lv = lvl_rd;
                if (r_func == mprq_pkg::FUNC_TICK) begin
                    age_we    = 1'b1;
                    age_wdata = rotate ? '0 : age_new;
                    n_rs      = rotate;
                end
                // Middle entry: bridge its neighbors around it.
                if ((r_func == mprq_pkg::FUNC_DEQ || rotate) && r_count[lvl_rd] > CW'(1)
                        && r_head[lvl_rd] != r_tid && r_tail[lvl_rd] != r_tid) begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    prev_we    = 1'b1;
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                end
                n_state = (r_func == mprq_pkg::FUNC_TICK && rotate) ? S_LNK : S_RES;
            end
            S_LNK: begin
                lvl_we = (r_func == mprq_pkg::FUNC_ENQ);
                if (r_count[r_lv] != '0) begin
                    next_we    = 1'b1;
                    next_waddr = r_tail[r_lv];
                    next_wdata = r_tid;
                    prev_we    = 1'b1;
                    prev_waddr = r_tid;
                    prev_wdata = r_tail[r_lv];
                end
                n_state = S_RES;
            end
            S_RES: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Most urgent nonempty level.
    always_comb begin
        found    = 1'b0;
        first_lv = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                found    = 1'b1;
                first_lv = LW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_aging_limit <= mprq_pkg::AGING_RESET;
            r_queued      <= '0;
            r_aged        <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_RES);
            if (i_cfg_we) begin
                r_aging_limit <= i_cfg_wdata;
            end
            if (age_we) begin
                r_aged[r_tid] <= 1'b1;
            end
            if (r_state == S_UNL && (r_func == mprq_pkg::FUNC_DEQ || rotate)) begin
                r_count[lvl_rd] <= r_count[lvl_rd] - CW'(1);
                if (r_func == mprq_pkg::FUNC_DEQ) begin
                    r_queued[r_tid] <= 1'b0;
                end
            end
            if (r_state == S_LNK) begin
                r_count[r_lv] <= r_count[r_lv] + CW'(1);
                r_queued[r_tid] <= 1'b1;
            end
        end
    end

    // Payload and list-end registers.
    always_ff @(posedge i_clk) begin
        r_lv  <= n_lv;
        r_rej <= n_rej;
        r_rs  <= n_rs;
        if (accept) begin
            r_func     <= i_func;
            r_tid      <= i_task_id;
            r_aged_hit <= r_aged[i_task_id];
        end
        if (r_state == S_UNL && (r_func == mprq_pkg::FUNC_DEQ || rotate)
                && r_count[lvl_rd] > CW'(1)) begin
            priority if (r_head[lvl_rd] == r_tid) begin
                r_head[lvl_rd] <= next_rd;
            end else if (r_tail[lvl_rd] == r_tid) begin
                r_tail[lvl_rd] <= prev_rd;
            end
        end
        if (r_state == S_LNK) begin
            if (r_count[r_lv] == '0) begin
                r_head[r_lv] <= r_tid;
            end
            r_tail[r_lv] <= r_tid;
        end
        if (r_state == S_RES) begin
            r_out_nv   <= found;
            r_out_task <= found ? r_head[first_lv] : '0;
            r_out_rs   <= r_rs && !r_rej;
            r_out_rej  <= r_rej;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_next_valid   = r_out_nv;
    assign o_next_task    = r_out_task;
    assign o_resched      = r_out_rs;
    assign o_rejected     = r_out_rej;

    `MPRQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy, "busy not raised after transfer")
    `MPRQ_ASSERT_NEXT(a_res_strobe, i_clk, i_rst_n, r_state == S_RES, o_result_valid, "result strobe missing")
    `MPRQ_ASSERT_NOW(a_empty_task, i_clk, i_rst_n, o_result_valid && !o_next_valid, o_next_task == '0, "task id on empty result")
    `MPRQ_ASSERT_NOW(a_rej_rs, i_clk, i_rst_n, o_result_valid && o_rejected, !o_resched, "reschedule on rejected event")

endmodule

`default_nettype wire

[hdl/mprq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
